>>> rtl/pgm_pkg.sv
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared types and constants for the path glob matcher.
// ----------------------------------------------------------------------------
package pgm_pkg;

    localparam int MAX_PATTERN_TOKENS = 64;
    localparam int MAX_GLOB_LENGTH    = 4096;

    // byte counters saturate at the top of their range
    localparam int            COUNT_W   = 13;
    localparam logic [12:0]   COUNT_SAT = 13'd8191;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_ANY   = 8'h3F;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_TEXT    = 2'd2,
        MODE_END     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_LIT   = 2'd0,
        KIND_ANY   = 2'd1,
        KIND_STAR  = 2'd2,
        KIND_DSTAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_STAR  = 2'd1,
        PEND_DSTAR = 2'd2
    } pend_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic pattern;
        logic flush;
        logic init;
        logic step;
        logic report;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic text_started;
        logic out_busy;
    } status_t;

endpackage

>>> rtl/pgm_in_if.sv
// ----------------------------------------------------------------------------
// pgm_in_if
// Input channel: mode and data byte with valid/ready.
// ----------------------------------------------------------------------------
interface pgm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

>>> rtl/pgm_out_if.sv
// ----------------------------------------------------------------------------
// pgm_out_if
// Result channel: matched and overlong with valid/ready.
// ----------------------------------------------------------------------------
interface pgm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic overlong;

    modport source (output valid, output matched, output overlong, input ready);
    modport sink   (input valid, input matched, input overlong, output ready);
endinterface

>>> rtl/path_glob_matcher.sv
// ----------------------------------------------------------------------------
// path_glob_matcher
// Glob matcher for paths with '?', '*' and '**' over a streamed text.
// ----------------------------------------------------------------------------
// order: a word executes in the cycle after acceptance, or after the pattern close
//   and column init steps when those run first (first text word, or end of text
//   with no text word); an end of text result is registered by its exec step
// pacing: no new word is taken until the sequencer is back in idle, and an
//   unaccepted result holds off the next word
// reset: asynchronous; clears control state and the match column, no clear pass
module path_glob_matcher #(
    parameter int MAX_PATTERN_TOKENS = pgm_pkg::MAX_PATTERN_TOKENS,
    parameter int MAX_GLOB_LENGTH    = pgm_pkg::MAX_GLOB_LENGTH
) (
    input  logic clk,
    input  logic rst_n,
    pgm_in_if.sink    item,
    pgm_out_if.source result
);

    pgm_pkg::cmd_t    cmd;
    pgm_pkg::status_t status;

    pgm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_mode  (item.mode),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    pgm_datapath #(
        .MAX_PATTERN_TOKENS (MAX_PATTERN_TOKENS),
        .MAX_GLOB_LENGTH    (MAX_GLOB_LENGTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (item.data_byte),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .matched      (result.matched),
        .overlong     (result.overlong)
    );

endmodule

>>> rtl/pgm_ctrl.sv
// ----------------------------------------------------------------------------
// pgm_ctrl
// Sequencer: takes a word, inserts the text-start steps, issues commands.
// ----------------------------------------------------------------------------
module pgm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [1:0]       item_mode,
    output logic             item_ready,
    input  pgm_pkg::status_t status,
    output pgm_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FLUSH = 4'b0010,
        S_INIT  = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    pgm_pkg::mode_t  mode_reg, mode_next;
    logic            take;
    pgm_pkg::mode_t  in_mode;

    assign in_mode    = pgm_pkg::mode_t'(item_mode);
    assign item_ready = (state_reg == S_IDLE) && !status.out_busy;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    mode_next = in_mode;
                    cmd.load  = 1'b1;
                    // first text word or end of text with no text: close the pattern first
                    if ((in_mode == pgm_pkg::MODE_TEXT || in_mode == pgm_pkg::MODE_END)
                        && !status.text_started)
                        state_next = S_FLUSH;
                    else
                        state_next = S_EXEC;
                end
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (mode_reg)
                    pgm_pkg::MODE_CLEAR:   cmd.clear   = 1'b1;
                    pgm_pkg::MODE_PATTERN: cmd.pattern = 1'b1;
                    pgm_pkg::MODE_TEXT:    cmd.step    = 1'b1;
                    pgm_pkg::MODE_END:     cmd.report  = 1'b1;
                    default:               cmd.clear   = 1'b1;
                endcase
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= pgm_pkg::MODE_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

>>> rtl/pgm_datapath.sv
// ----------------------------------------------------------------------------
// pgm_datapath
// Token cells, match column, counters and the result register.
// ----------------------------------------------------------------------------
module pgm_datapath #(
    parameter int MAX_PATTERN_TOKENS = pgm_pkg::MAX_PATTERN_TOKENS,
    parameter int MAX_GLOB_LENGTH    = pgm_pkg::MAX_GLOB_LENGTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  pgm_pkg::cmd_t    cmd,
    output pgm_pkg::status_t status,
    output logic             result_valid,
    input  logic             result_ready,
    output logic             matched,
    output logic             overlong
);

    localparam int N  = MAX_PATTERN_TOKENS;
    localparam int CW = $clog2(N + 1);
    localparam int SW = CW + 1;
    localparam int BW = pgm_pkg::COUNT_W;

    logic [7:0]           byte_reg;
    pgm_pkg::kind_t       kind_reg [N];
    logic [7:0]           char_reg [N];
    logic [N:0]           col_reg, col_next;
    pgm_pkg::pend_t       pend_reg, pend_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [BW-1:0]        pcount_reg, pcount_next;
    logic [BW-1:0]        tcount_reg, tcount_next;
    logic                 started_reg, started_next;
    logic                 ovf_reg, ovf_next;
    logic                 out_valid_reg, matched_reg, overlong_reg;

    logic                 pat_en;
    logic                 e0_v, e1_v;
    pgm_pkg::kind_t       e0_k, e1_k;
    logic [7:0]           e0_c, e1_c;
    logic                 normal;
    logic [SW-1:0]        slot0, slot1;
    logic                 w0, w1;
    logic [N-1:0]         active;
    logic                 is_slash;

    assign pat_en   = cmd.pattern && !started_reg;
    assign is_slash = (byte_reg == pgm_pkg::CHAR_SLASH);

    // token emission: one pattern word can close a star and add a token
    always_comb
    begin
        e0_v      = 1'b0;
        e0_k      = pgm_pkg::KIND_LIT;
        e0_c      = '0;
        e1_v      = 1'b0;
        e1_k      = pgm_pkg::KIND_LIT;
        e1_c      = '0;
        normal    = 1'b1;
        pend_next = pend_reg;
        if (cmd.clear)
        begin
            pend_next = pgm_pkg::PEND_NONE;
        end
        else if (cmd.flush)
        begin
            e0_v      = (pend_reg != pgm_pkg::PEND_NONE);
            e0_k      = (pend_reg == pgm_pkg::PEND_DSTAR) ? pgm_pkg::KIND_DSTAR
                                                          : pgm_pkg::KIND_STAR;
            pend_next = pgm_pkg::PEND_NONE;
        end
        else if (pat_en)
        begin
            if (pend_reg == pgm_pkg::PEND_STAR)
            begin
                if (byte_reg == pgm_pkg::CHAR_STAR)
                begin
                    pend_next = pgm_pkg::PEND_DSTAR;
                    normal    = 1'b0;
                end
                else
                begin
                    e0_v      = 1'b1;
                    e0_k      = pgm_pkg::KIND_STAR;
                    pend_next = pgm_pkg::PEND_NONE;
                end
            end
            else if (pend_reg == pgm_pkg::PEND_DSTAR)
            begin
                e0_v      = 1'b1;
                e0_k      = pgm_pkg::KIND_DSTAR;
                pend_next = pgm_pkg::PEND_NONE;
                // double star swallows one slash
                if (is_slash)
                    normal = 1'b0;
            end
            if (normal)
            begin
                if (byte_reg == pgm_pkg::CHAR_STAR)
                begin
                    pend_next = pgm_pkg::PEND_STAR;
                end
                else if (e0_v)
                begin
                    e1_v = 1'b1;
                    e1_k = (byte_reg == pgm_pkg::CHAR_ANY) ? pgm_pkg::KIND_ANY
                                                           : pgm_pkg::KIND_LIT;
                    e1_c = byte_reg;
                end
                else
                begin
                    e0_v = 1'b1;
                    e0_k = (byte_reg == pgm_pkg::CHAR_ANY) ? pgm_pkg::KIND_ANY
                                                           : pgm_pkg::KIND_LIT;
                    e0_c = byte_reg;
                end
            end
        end
    end

    assign slot0 = SW'(count_reg);
    assign w0    = e0_v && (slot0 < SW'(N));
    assign slot1 = w0 ? slot0 + SW'(1) : slot0;
    assign w1    = e1_v && (slot1 < SW'(N));

    always_comb
    begin
        for (int t = 0; t < N; t++)
            active[t] = (CW'(t) < count_reg);
    end

    // match column: clear and report reset it; init and step ripple through the star tokens
    always_comb
    begin
        col_next = col_reg;
        if (cmd.clear || cmd.report)
        begin
            col_next    = '0;
            col_next[0] = 1'b1;
        end
        else if (cmd.init)
        begin
            col_next[0] = 1'b1;
            for (int t = 0; t < N; t++)
                col_next[t+1] = active[t] && col_next[t] && kind_reg[t][1];
        end
        else if (cmd.step)
        begin
            col_next[0] = 1'b0;
            for (int t = 0; t < N; t++)
            begin
                if (active[t])
                begin
                    unique case (kind_reg[t])
                        pgm_pkg::KIND_DSTAR:
                            col_next[t+1] = col_reg[t+1] || col_next[t];
                        pgm_pkg::KIND_STAR:
                            col_next[t+1] = col_reg[t+1] || (!is_slash && col_next[t]);
                        pgm_pkg::KIND_ANY:
                            col_next[t+1] = col_reg[t] && !is_slash;
                        default:
                            col_next[t+1] = col_reg[t] && (byte_reg == char_reg[t]);
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        pcount_next  = pcount_reg;
        tcount_next  = tcount_reg;
        started_next = started_reg;
        ovf_next     = ovf_reg;
        if (cmd.clear)
        begin
            count_next   = '0;
            pcount_next  = '0;
            tcount_next  = '0;
            started_next = 1'b0;
            ovf_next     = 1'b0;
        end
        else
        begin
            count_next = CW'(slot1 + SW'(w1));
            if ((e0_v && !w0) || (e1_v && !w1))
                ovf_next = 1'b1;
            if (pat_en)
            begin
                if (pcount_reg >= BW'(MAX_GLOB_LENGTH))
                    ovf_next = 1'b1;
                if (pcount_reg < pgm_pkg::COUNT_SAT)
                    pcount_next = pcount_reg + BW'(1);
            end
            if (cmd.step)
            begin
                if (tcount_reg >= BW'(MAX_GLOB_LENGTH))
                    ovf_next = 1'b1;
                if (tcount_reg < pgm_pkg::COUNT_SAT)
                    tcount_next = tcount_reg + BW'(1);
            end
            if (cmd.init)
                started_next = 1'b1;
            if (cmd.report)
            begin
                started_next = 1'b0;
                tcount_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= (N+1)'(1);
            pend_reg      <= pgm_pkg::PEND_NONE;
            count_reg     <= '0;
            pcount_reg    <= '0;
            tcount_reg    <= '0;
            started_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            pcount_reg  <= pcount_next;
            tcount_reg  <= tcount_next;
            started_reg <= started_next;
            ovf_reg     <= ovf_next;
            if (cmd.report)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            byte_reg <= data_byte;
        if (cmd.report)
        begin
            matched_reg  <= !ovf_reg && col_reg[count_reg];
            overlong_reg <= ovf_reg;
        end
    end

    // token cells, each written when the emit slot lands on it
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (w0 && slot0 == SW'(g))
            begin
                kind_reg[g] <= e0_k;
                char_reg[g] <= e0_c;
            end
            else if (w1 && slot1 == SW'(g))
            begin
                kind_reg[g] <= e1_k;
                char_reg[g] <= e1_c;
            end
        end
    end

    assign status.text_started = started_reg;
    assign status.out_busy     = out_valid_reg && !result_ready;
    assign result_valid        = out_valid_reg;
    assign matched             = matched_reg;
    assign overlong            = overlong_reg;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams patterns and path texts into path_glob_matcher and checks every
// end-of-text verdict against a cycle-free glob predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pgm_pkg::*;

    typedef struct packed {
        logic matched;
        logic overlong;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    pgm_in_if  item_if ();
    pgm_out_if result_if ();

    path_glob_matcher u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // glob predictor state
    kind_t                       tok_kind [MAX_PATTERN_TOKENS];
    logic [7:0]                  tok_char [MAX_PATTERN_TOKENS];
    logic [MAX_PATTERN_TOKENS:0] live;
    pend_t                       pend;
    int                          n_tok;
    int                          pat_len;
    int                          txt_len;
    bit                          in_text;
    bit                          overflow;

    verdict_t   verdicts[$];
    logic [7:0] pat_q[$];
    logic [7:0] text_q[$];
    int         words_sent;
    int         n_bad;
    bit         steady;

    function automatic void add_token(kind_t k, logic [7:0] ch);
        if (n_tok >= MAX_PATTERN_TOKENS)
        begin
            overflow = 1'b1;
            return;
        end
        tok_kind[n_tok] = k;
        tok_char[n_tok] = ch;
        n_tok++;
    endfunction

    function automatic void close_star();
        if (pend == PEND_STAR)
            add_token(KIND_STAR, 8'h00);
        else if (pend == PEND_DSTAR)
            add_token(KIND_DSTAR, 8'h00);
        pend = PEND_NONE;
    endfunction

    function automatic int count_up(int c);
        if (c >= MAX_GLOB_LENGTH)
            overflow = 1'b1;
        return (c < int'(COUNT_SAT)) ? c + 1 : int'(COUNT_SAT);
    endfunction

    function automatic void reset_text();
        live    = '0;
        live[0] = 1'b1;
        txt_len = 0;
        in_text = 1'b0;
    endfunction

    function automatic void reset_glob();
        foreach (tok_kind[i])
        begin
            tok_kind[i] = KIND_LIT;
            tok_char[i] = 8'h00;
        end
        pend     = PEND_NONE;
        n_tok    = 0;
        pat_len  = 0;
        overflow = 1'b0;
        reset_text();
    endfunction

    // empty-text column: bit zero carried through leading star tokens
    function automatic void open_text();
        close_star();
        live[0] = 1'b1;
        for (int t = 0; t < n_tok; t++)
            live[t + 1] = live[t] && (tok_kind[t] == KIND_STAR || tok_kind[t] == KIND_DSTAR);
        in_text = 1'b1;
    endfunction

    function automatic void absorb_pattern(logic [7:0] b);
        if (in_text)
            return;
        pat_len = count_up(pat_len);
        if (pend == PEND_STAR)
        begin
            if (b == CHAR_STAR)
            begin
                pend = PEND_DSTAR;
                return;
            end
            close_star();
        end
        else if (pend == PEND_DSTAR)
        begin
            close_star();
            // '**/' swallows the slash
            if (b == CHAR_SLASH)
                return;
        end
        if (b == CHAR_STAR)
            pend = PEND_STAR;
        else if (b == CHAR_ANY)
            add_token(KIND_ANY, 8'h00);
        else
            add_token(KIND_LIT, b);
    endfunction

    function automatic void absorb_text(logic [7:0] c);
        logic old_prev;
        logic old_cur;
        logic nv;
        if (!in_text)
            open_text();
        txt_len  = count_up(txt_len);
        old_prev = live[0];
        live[0]  = 1'b0;
        for (int t = 0; t < n_tok; t++)
        begin
            old_cur = live[t + 1];
            case (tok_kind[t])
                KIND_DSTAR: nv = old_cur || live[t];
                KIND_STAR:  nv = old_cur || (c != CHAR_SLASH && live[t]);
                KIND_ANY:   nv = old_prev && c != CHAR_SLASH;
                default:    nv = old_prev && c == tok_char[t];
            endcase
            live[t + 1] = nv;
            old_prev    = old_cur;
        end
    endfunction

    function automatic void predict_word(mode_t m, logic [7:0] b);
        verdict_t v;
        case (m)
            MODE_CLEAR:   reset_glob();
            MODE_PATTERN: absorb_pattern(b);
            MODE_TEXT:    absorb_text(b);
            default:
            begin
                if (!in_text)
                    open_text();
                v.matched  = !overflow && live[n_tok];
                v.overlong = overflow;
                verdicts.push_back(v);
                reset_text();
            end
        endcase
    endfunction

    task automatic send_word(mode_t m, logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.mode      <= m;
        item_if.data_byte <= b;
        do @(posedge clk); while (!item_if.ready);
        predict_word(m, b);
        words_sent++;
    endtask

    task automatic send_bytes(mode_t m, string s);
        for (int i = 0; i < s.len(); i++)
            send_word(m, s[i]);
    endtask

    task automatic send_text_end(string s);
        send_bytes(MODE_TEXT, s);
        send_word(MODE_END, 8'hFF);
    endtask

    task automatic send_run(mode_t m, logic [7:0] b, int n);
        repeat (n) send_word(m, b);
    endtask

    function automatic logic [7:0] pick_char(bit with_slash);
        int r;
        r = $urandom_range(0, 9);
        if (r == 9)
            return 8'($urandom_range(0, 255));
        if (with_slash && r < 3)
            return CHAR_SLASH;
        return (r % 2) ? "a" : "b";
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return pick_char(1'b0);
            3:       return CHAR_SLASH;
            4, 5, 6: return CHAR_STAR;
            7:       return CHAR_ANY;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // text drawn from the pattern so that most texts come close to matching
    task automatic make_text();
        int i;
        int n;
        text_q.delete();
        i = 0;
        while (i < pat_q.size())
        begin
            if (pat_q[i] == CHAR_STAR && i + 1 < pat_q.size() && pat_q[i + 1] == CHAR_STAR)
            begin
                n = $urandom_range(0, 4);
                repeat (n) text_q.push_back(pick_char(1'b1));
                i += 2;
            end
            else if (pat_q[i] == CHAR_STAR)
            begin
                n = $urandom_range(0, 3);
                repeat (n) text_q.push_back(pick_char(1'b0));
                i++;
            end
            else if (pat_q[i] == CHAR_ANY)
            begin
                text_q.push_back(pick_char(1'b0));
                i++;
            end
            else
            begin
                text_q.push_back(pat_q[i]);
                i++;
            end
        end
        if ($urandom_range(0, 2) == 0)
        begin
            case ($urandom_range(0, 2))
                0:
                    if (text_q.size() > 0)
                        text_q[$urandom_range(0, text_q.size() - 1)] = pick_char(1'b1);
                1:
                    if (text_q.size() > 0)
                        text_q.delete($urandom_range(0, text_q.size() - 1));
                default:
                    text_q.push_back(pick_char(1'b1));
            endcase
        end
    endtask

    task automatic run_glob();
        int n_pat;
        int n_txt;
        logic [7:0] b;
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) != 0 || pat_q.size() > 40)
        begin
            send_word(MODE_CLEAR, 8'($urandom));
            pat_q.delete();
        end
        n_pat = $urandom_range(0, 10);
        repeat (n_pat)
        begin
            b = pick_pattern_byte();
            pat_q.push_back(b);
            send_word(MODE_PATTERN, b);
        end
        n_txt = $urandom_range(1, 4);
        repeat (n_txt)
        begin
            make_text();
            foreach (text_q[k])
            begin
                send_word(MODE_TEXT, text_q[k]);
                // pattern word inside a text must be dropped
                if (k == 0 && $urandom_range(0, 7) == 0)
                    send_word(MODE_PATTERN, pick_pattern_byte());
            end
            send_word(MODE_END, 8'($urandom));
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3))
                send_word(mode_t'($urandom_range(0, 3)), 8'($urandom));
    endtask

    task automatic test_literals_and_any();
        send_word(MODE_CLEAR, 8'hFF);
        send_bytes(MODE_PATTERN, "a?c");
        send_text_end("abc");
        send_text_end("a/c");
        send_word(MODE_END, 8'h00);
        send_word(MODE_CLEAR, 8'h00);
        send_word(MODE_PATTERN, 8'hFF);
        send_word(MODE_PATTERN, 8'h00);
        send_word(MODE_TEXT, 8'hFF);
        send_word(MODE_TEXT, 8'h00);
        send_word(MODE_END, 8'hFF);
        send_word(MODE_TEXT, 8'h00);
        send_word(MODE_TEXT, 8'hFF);
        send_word(MODE_END, 8'h00);
    endtask

    task automatic test_star_forms();
        send_word(MODE_CLEAR, 8'h00);
        send_bytes(MODE_PATTERN, "*");
        send_word(MODE_END, 8'h00);
        send_text_end("ab/c");
        send_text_end("abc");
        send_word(MODE_CLEAR, 8'h00);
        send_bytes(MODE_PATTERN, "**/x");
        send_text_end("x");
        send_text_end("a/b/x");
        send_text_end("ax");
        send_word(MODE_CLEAR, 8'h00);
        send_bytes(MODE_PATTERN, "a**");
        send_text_end("a/b");
        send_word(MODE_CLEAR, 8'h00);
        send_bytes(MODE_PATTERN, "***?");
        send_text_end("/q");
    endtask

    task automatic test_mid_text_pattern();
        send_word(MODE_CLEAR, 8'h00);
        send_bytes(MODE_PATTERN, "ab");
        send_word(MODE_TEXT, "a");
        send_word(MODE_PATTERN, "b");
        send_word(MODE_TEXT, "b");
        send_word(MODE_END, 8'h00);
        // pattern kept after end of text, so it can grow
        send_word(MODE_PATTERN, "c");
        send_text_end("abc");
    endtask

    task automatic test_token_overflow();
        steady = 1'b1;
        send_word(MODE_CLEAR, 8'h00);
        send_run(MODE_PATTERN, "a", MAX_PATTERN_TOKENS + 1);
        send_run(MODE_TEXT, "a", MAX_PATTERN_TOKENS);
        send_word(MODE_END, 8'h00);
        send_text_end("a");
        send_word(MODE_CLEAR, 8'h00);
        send_bytes(MODE_PATTERN, "a");
        send_text_end("a");
        steady = 1'b0;
    endtask

    task automatic test_pattern_too_long();
        steady = 1'b1;
        send_word(MODE_CLEAR, 8'h00);
        send_run(MODE_PATTERN, "b", MAX_GLOB_LENGTH + 1);
        send_word(MODE_END, 8'h00);
        send_word(MODE_CLEAR, 8'h00);
        steady = 1'b0;
    endtask

    task automatic test_text_too_long();
        steady = 1'b1;
        send_word(MODE_CLEAR, 8'h00);
        send_bytes(MODE_PATTERN, "**");
        send_run(MODE_TEXT, "x", MAX_GLOB_LENGTH);
        send_word(MODE_END, 8'h00);
        send_run(MODE_TEXT, "x", MAX_GLOB_LENGTH + 1);
        send_word(MODE_END, 8'h00);
        // flag stays up for later texts until a clear
        send_text_end("x");
        send_word(MODE_CLEAR, 8'h00);
        send_bytes(MODE_PATTERN, "**");
        send_word(MODE_END, 8'h00);
        steady = 1'b0;
    endtask

    task automatic test_random();
        int first;
        first = words_sent;
        while (words_sent - first < 1800)
            run_glob();
        steady = 1'b0;
    endtask

    initial
    begin
        item_if.valid     = 1'b0;
        item_if.mode      = MODE_CLEAR;
        item_if.data_byte = 8'h00;
        rst_n             = 1'b0;
        reset_glob();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_literals_and_any();
        test_star_forms();
        test_mid_text_pattern();
        test_token_overflow();
        test_pattern_too_long();
        test_text_too_long();
        test_random();

        @(negedge clk);
        item_if.valid <= 1'b0;
        while (verdicts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_bad == 0)
            $display("[path_glob_matcher] OK");
        else
            $display("[path_glob_matcher] ERROR");
        $finish;
    end

    initial
    begin : verdict_check
        int       stall;
        verdict_t want;
        result_if.ready = 1'b0;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            @(negedge clk);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (result_if.valid !== 1'b1);
            if (verdicts.size() == 0)
            begin
                $error("unexpected word: matched %0b overlong %0b",
                       result_if.matched, result_if.overlong);
                n_bad++;
            end
            else
            begin
                want = verdicts.pop_front();
                if (result_if.matched !== want.matched)
                begin
                    $error("matched: expected %0b, got %0b", want.matched, result_if.matched);
                    n_bad++;
                end
                if (result_if.overlong !== want.overlong)
                begin
                    $error("overlong: expected %0b, got %0b", want.overlong,
                           result_if.overlong);
                    n_bad++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("[path_glob_matcher] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pgm_pkg.sv
rtl/pgm_in_if.sv
rtl/pgm_out_if.sv
rtl/pgm_ctrl.sv
rtl/pgm_datapath.sv
rtl/path_glob_matcher.sv
tb/tb_top.sv
